### design/ogft_pkg.sv
package ogft_pkg;

    localparam int GRID_X_DEF = 64;
    localparam int GRID_Y_DEF = 64;
    localparam int GRID_Z_DEF = 16;

    localparam int XY_W       = 6;
    localparam int Z_W        = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 6;
    localparam int CMP_W      = 12;
    localparam int STEP_W     = 3;

    typedef logic [1:0] t_cell;

    localparam t_cell CELL_UNKNOWN  = 2'd0;
    localparam t_cell CELL_FREE     = 2'd1;
    localparam t_cell CELL_OCCUPIED = 2'd2;

    typedef enum logic {
        CMD_WRITE,
        CMD_QUERY
    } t_cmd;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_X = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_Y = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_Y = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_Z = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_Z = 3'd5;

    localparam logic [XY_W-1:0] WIN_MAX_XY_RST = 6'd63;
    localparam logic [Z_W-1:0]  WIN_MAX_Z_RST  = 4'd15;

    localparam logic [STEP_W-1:0] STEP_CENTER = 3'd0;
    localparam logic [STEP_W-1:0] STEP_ZM     = 3'd1;
    localparam logic [STEP_W-1:0] STEP_ZP     = 3'd2;
    localparam logic [STEP_W-1:0] STEP_XM     = 3'd3;
    localparam logic [STEP_W-1:0] STEP_XP     = 3'd4;
    localparam logic [STEP_W-1:0] STEP_YM     = 3'd5;
    localparam logic [STEP_W-1:0] STEP_YP     = 3'd6;
    localparam logic [STEP_W-1:0] STEP_LAST   = 3'd7;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_DONE
    } t_state;

endpackage

### design/ogft_req_if.sv
interface ogft_req_if import ogft_pkg::*; ();

    logic            valid;
    logic            ready;
    t_cmd            cmd;
    logic [XY_W-1:0] cell_x;
    logic [XY_W-1:0] cell_y;
    logic [Z_W-1:0]  cell_z;
    t_cell           new_state;

    modport source (
        output valid, cmd, cell_x, cell_y, cell_z, new_state,
        input  ready
    );

    modport sink (
        input  valid, cmd, cell_x, cell_y, cell_z, new_state,
        output ready
    );

endinterface

### design/ogft_rsp_if.sv
interface ogft_rsp_if import ogft_pkg::*; ();

    logic  valid;
    logic  ready;
    logic  is_frontier;
    t_cell cell_state;

    modport source (
        output valid, is_frontier, cell_state,
        input  ready
    );

    modport sink (
        input  valid, is_frontier, cell_state,
        output ready
    );

endinterface

### design/occupancy_grid_frontier_test.sv
// Frontier test on a 3D occupancy grid held in one single-port synchronous memory of
// 2-bit cell states (unknown, free, occupied). After reset the block sweeps the memory
// to unknown, one cell per cycle, through all 2**(clog2(GRID_X)+clog2(GRID_Y)+
// clog2(GRID_Z)) cells (65536 at the default size); no request is taken during that
// sweep, while window register writes are. A write request reads the cell and then
// stores the new state if that is free or occupied; no new request is taken until
// its response is loaded. A query request reads the cell and its six neighbors
// through the one memory port, one read per cycle, and the next request can be
// accepted on the cycle after the response is loaded. A request for a cell outside
// the grid writes no memory and goes straight to the done state. A finished response
// waits in an output register, and the next request is accepted while it waits.
module occupancy_grid_frontier_test import ogft_pkg::*; #(
    parameter int GRID_X = GRID_X_DEF,
    parameter int GRID_Y = GRID_Y_DEF,
    parameter int GRID_Z = GRID_Z_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    ogft_req_if.sink              i_req,
    ogft_rsp_if.source            o_rsp
);

    localparam int XW    = $clog2(GRID_X);
    localparam int YW    = $clog2(GRID_Y);
    localparam int ZW    = $clog2(GRID_Z);
    localparam int AW    = XW + YW + ZW;
    localparam int DEPTH = 1 << AW;

    localparam logic [CMP_W-1:0] GX = CMP_W'(GRID_X);
    localparam logic [CMP_W-1:0] GY = CMP_W'(GRID_Y);
    localparam logic [CMP_W-1:0] GZ = CMP_W'(GRID_Z);
    localparam logic [CMP_W-1:0] ONE = CMP_W'(1);

    t_cell r_mem [DEPTH];
    t_cell r_rd_data;

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    logic [AW-1:0]     r_clr, n_clr;
    t_cmd              r_query, n_query;
    logic [XY_W-1:0]   r_x, r_y;
    logic [Z_W-1:0]    r_z;
    t_cell             r_ns;
    logic              r_in_win, n_in_win;
    t_cell             r_center, n_center;
    logic              r_xy_free, n_xy_free;
    logic              r_z_free, n_z_free;
    logic              r_rd_ok;

    logic              r_out_valid;
    logic              r_out_frontier;
    t_cell             r_out_state;

    logic [XY_W-1:0]   r_win_min_x, r_win_max_x;
    logic [XY_W-1:0]   r_win_min_y, r_win_max_y;
    logic [Z_W-1:0]    r_win_min_z, r_win_max_z;

    logic              req_ready;
    logic              accept;
    logic              out_load;
    logic              mem_we;
    logic [AW-1:0]     mem_addr;
    t_cell             mem_wdata;

    logic              req_in_grid;
    logic              req_in_win;
    logic              ns_valid;
    logic [STEP_W-1:0] rd_step;
    logic              frontier;

    logic [CMP_W-1:0]  ex, ey, ez;
    logic [CMP_W-1:0]  nx, ny, nz;
    logic              nb_ok;
    logic [AW-1:0]     nb_addr;
    logic [AW-1:0]     center_addr;

    assign accept   = i_req.valid && req_ready;
    assign ns_valid = (r_ns == CELL_FREE) || (r_ns == CELL_OCCUPIED);
    assign rd_step  = r_step - STEP_W'(1);
    assign frontier = (r_query == CMD_QUERY) && r_in_win && (r_center == CELL_UNKNOWN)
                      && r_xy_free && !r_z_free;

    assign req_in_grid = (CMP_W'(i_req.cell_x) < GX) && (CMP_W'(i_req.cell_y) < GY)
                         && (CMP_W'(i_req.cell_z) < GZ);
    assign req_in_win  = (i_req.cell_x >= r_win_min_x) && (i_req.cell_x <= r_win_max_x)
                         && (i_req.cell_y >= r_win_min_y) && (i_req.cell_y <= r_win_max_y)
                         && (i_req.cell_z >= r_win_min_z) && (i_req.cell_z <= r_win_max_z);

    assign ex = CMP_W'(r_x);
    assign ey = CMP_W'(r_y);
    assign ez = CMP_W'(r_z);
    assign center_addr = {ez[ZW-1:0], ey[YW-1:0], ex[XW-1:0]};
    assign nb_addr     = {nz[ZW-1:0], ny[YW-1:0], nx[XW-1:0]};

    always_comb begin
        nx    = ex;
        ny    = ey;
        nz    = ez;
        nb_ok = 1'b0;
        unique case (r_step)
            STEP_CENTER: begin
                nb_ok = 1'b1;
            end
            STEP_ZM: begin
                nz    = ez - ONE;
                nb_ok = (ez != '0);
            end
            STEP_ZP: begin
                nz    = ez + ONE;
                nb_ok = (nz < GZ);
            end
            STEP_XM: begin
                nx    = ex - ONE;
                nb_ok = (ex != '0);
            end
            STEP_XP: begin
                nx    = ex + ONE;
                nb_ok = (nx < GX);
            end
            STEP_YM: begin
                ny    = ey - ONE;
                nb_ok = (ey != '0);
            end
            STEP_YP: begin
                ny    = ey + ONE;
                nb_ok = (ny < GY);
            end
            default: begin
                nb_ok = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr == '1) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    n_state = req_in_grid ? ST_READ : ST_DONE;
                end
            end
            ST_READ: begin
                if ((r_query == CMD_WRITE && r_step == STEP_ZM) || r_step == STEP_LAST) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        req_ready = 1'b0;
        out_load  = 1'b0;
        mem_we    = 1'b0;
        mem_addr  = nb_addr;
        mem_wdata = r_ns;
        unique case (r_state)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_addr  = r_clr;
                mem_wdata = CELL_UNKNOWN;
            end
            ST_IDLE: begin
                req_ready = 1'b1;
            end
            ST_READ: begin
                if (r_query == CMD_WRITE && r_step == STEP_ZM) begin
                    mem_we   = ns_valid;
                    mem_addr = center_addr;
                end
            end
            ST_DONE: begin
                out_load = !r_out_valid || o_rsp.ready;
            end
            default: begin
                req_ready = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_step    = r_step;
        n_clr     = r_clr;
        n_query   = r_query;
        n_in_win  = r_in_win;
        n_center  = r_center;
        n_xy_free = r_xy_free;
        n_z_free  = r_z_free;
        if (r_state == ST_CLEAR) begin
            n_clr = r_clr + AW'(1);
        end
        if (accept) begin
            n_step    = STEP_CENTER;
            n_query   = req_in_grid ? i_req.cmd : CMD_WRITE;
            n_in_win  = req_in_win;
            n_center  = CELL_UNKNOWN;
            n_xy_free = 1'b0;
            n_z_free  = 1'b0;
        end
        if (r_state == ST_READ) begin
            n_step = r_step + STEP_W'(1);
            if (r_step != STEP_CENTER) begin
                if (rd_step == STEP_CENTER) begin
                    n_center = (r_query == CMD_WRITE && ns_valid) ? r_ns : r_rd_data;
                end else if (r_rd_ok && r_rd_data == CELL_FREE) begin
                    if (rd_step == STEP_ZM || rd_step == STEP_ZP) begin
                        n_z_free = 1'b1;
                    end else begin
                        n_xy_free = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= mem_wdata;
        end
        r_rd_data <= r_mem[mem_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
            r_win_min_x <= '0;
            r_win_max_x <= WIN_MAX_XY_RST;
            r_win_min_y <= '0;
            r_win_max_y <= WIN_MAX_XY_RST;
            r_win_min_z <= '0;
            r_win_max_z <= WIN_MAX_Z_RST;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_MIN_X: r_win_min_x <= i_cfg_data;
                    REG_MAX_X: r_win_max_x <= i_cfg_data;
                    REG_MIN_Y: r_win_min_y <= i_cfg_data;
                    REG_MAX_Y: r_win_max_y <= i_cfg_data;
                    REG_MIN_Z: r_win_min_z <= i_cfg_data[Z_W-1:0];
                    REG_MAX_Z: r_win_max_z <= i_cfg_data[Z_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_step    <= n_step;
        r_query   <= n_query;
        r_in_win  <= n_in_win;
        r_center  <= n_center;
        r_xy_free <= n_xy_free;
        r_z_free  <= n_z_free;
        r_rd_ok   <= nb_ok;
        if (accept) begin
            r_x  <= i_req.cell_x;
            r_y  <= i_req.cell_y;
            r_z  <= i_req.cell_z;
            r_ns <= i_req.new_state;
        end
        if (out_load) begin
            r_out_frontier <= frontier;
            r_out_state    <= r_center;
        end
    end

    assign i_req.ready       = req_ready;
    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.is_frontier = r_out_frontier;
    assign o_rsp.cell_state  = r_out_state;

    a_frontier_unknown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.is_frontier) |-> (o_rsp.cell_state == CELL_UNKNOWN))
        else $error("frontier response for a known cell");

    a_no_req_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> !i_req.ready)
        else $error("request taken during the clearing sweep");

    a_write_only_in_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_we && r_state != ST_CLEAR) |-> (r_query == CMD_WRITE && r_step == STEP_ZM))
        else $error("memory written outside a write request");

endmodule

### verif/tb.sv
`timescale 1ns / 100ps

module tb;
    import ogft_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int X_TOP = GRID_X_DEF - 1;
    localparam int Y_TOP = GRID_Y_DEF - 1;
    localparam int Z_TOP = GRID_Z_DEF - 1;
    localparam int PHASE_ITEMS = 150;
    localparam int PHASE_COUNT = 7;

    typedef struct packed {
        logic  fr;
        t_cell st;
    } t_cell_answer;

    typedef struct packed {
        t_cmd            cmd;
        logic [XY_W-1:0] x;
        logic [XY_W-1:0] y;
        logic [Z_W-1:0]  z;
        t_cell           ns;
        logic            typed;
        logic            fr;
        t_cell           st;
    } t_dir_row;

    localparam int DIR_COUNT = 25;
    localparam t_dir_row DIR_ROWS [DIR_COUNT] = '{
        '{CMD_QUERY, 6'd0,  6'd0,  4'd0,  CELL_UNKNOWN,  1'b1, 1'b0, CELL_UNKNOWN},
        '{CMD_WRITE, 6'd0,  6'd0,  4'd0,  CELL_FREE,     1'b1, 1'b0, CELL_FREE},
        '{CMD_QUERY, 6'd1,  6'd0,  4'd0,  CELL_UNKNOWN,  1'b1, 1'b1, CELL_UNKNOWN},
        '{CMD_QUERY, 6'd0,  6'd0,  4'd0,  CELL_UNKNOWN,  1'b1, 1'b0, CELL_FREE},
        '{CMD_QUERY, 6'd0,  6'd1,  4'd0,  CELL_UNKNOWN,  1'b1, 1'b1, CELL_UNKNOWN},
        '{CMD_WRITE, 6'd63, 6'd63, 4'd15, CELL_OCCUPIED, 1'b1, 1'b0, CELL_OCCUPIED},
        '{CMD_WRITE, 6'd63, 6'd63, 4'd15, CELL_UNKNOWN,  1'b1, 1'b0, CELL_OCCUPIED},
        '{CMD_WRITE, 6'd63, 6'd63, 4'd15, 2'd3,          1'b1, 1'b0, CELL_OCCUPIED},
        '{CMD_QUERY, 6'd63, 6'd62, 4'd15, CELL_UNKNOWN,  1'b1, 1'b0, CELL_UNKNOWN},
        '{CMD_WRITE, 6'd62, 6'd63, 4'd15, CELL_FREE,     1'b1, 1'b0, CELL_FREE},
        '{CMD_QUERY, 6'd62, 6'd62, 4'd15, CELL_UNKNOWN,  1'b1, 1'b1, CELL_UNKNOWN},
        '{CMD_QUERY, 6'd61, 6'd63, 4'd15, CELL_UNKNOWN,  1'b1, 1'b1, CELL_UNKNOWN},
        '{CMD_WRITE, 6'd21, 6'd20, 4'd5,  CELL_FREE,     1'b1, 1'b0, CELL_FREE},
        '{CMD_QUERY, 6'd20, 6'd20, 4'd5,  CELL_UNKNOWN,  1'b1, 1'b1, CELL_UNKNOWN},
        '{CMD_WRITE, 6'd20, 6'd20, 4'd4,  CELL_FREE,     1'b1, 1'b0, CELL_FREE},
        '{CMD_QUERY, 6'd20, 6'd20, 4'd5,  CELL_UNKNOWN,  1'b1, 1'b0, CELL_UNKNOWN},
        '{CMD_WRITE, 6'd20, 6'd20, 4'd4,  CELL_OCCUPIED, 1'b1, 1'b0, CELL_OCCUPIED},
        '{CMD_QUERY, 6'd20, 6'd20, 4'd5,  CELL_UNKNOWN,  1'b1, 1'b1, CELL_UNKNOWN},
        '{CMD_WRITE, 6'd20, 6'd20, 4'd6,  CELL_FREE,     1'b1, 1'b0, CELL_FREE},
        '{CMD_QUERY, 6'd20, 6'd20, 4'd5,  CELL_UNKNOWN,  1'b1, 1'b0, CELL_UNKNOWN},
        '{CMD_QUERY, 6'd20, 6'd20, 4'd6,  CELL_UNKNOWN,  1'b1, 1'b0, CELL_FREE},
        '{CMD_WRITE, 6'd0,  6'd0,  4'd0,  CELL_OCCUPIED, 1'b1, 1'b0, CELL_OCCUPIED},
        '{CMD_QUERY, 6'd1,  6'd0,  4'd0,  CELL_UNKNOWN,  1'b1, 1'b0, CELL_UNKNOWN},
        '{CMD_QUERY, 6'd62, 6'd63, 4'd14, CELL_UNKNOWN,  1'b0, 1'b0, CELL_UNKNOWN},
        '{CMD_WRITE, 6'd31, 6'd32, 4'd7,  2'd3,          1'b0, 1'b0, CELL_UNKNOWN}
    };

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    ogft_req_if req_bus ();
    ogft_rsp_if rsp_bus ();

    occupancy_grid_frontier_test dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_bus),
        .o_rsp      (rsp_bus)
    );

    t_cell        grid_model [GRID_X_DEF*GRID_Y_DEF*GRID_Z_DEF];
    int           win_lo_x, win_hi_x, win_lo_y, win_hi_y, win_lo_z, win_hi_z;
    t_cell_answer cell_answers_due [$];
    t_cell_answer answer_head;
    int           err_count;
    int           cycle_count;
    bit           calm;
    int           stall_len;
    int           run_len;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end else if (r < 98) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic int clamp(input int v, input int top);
        if (v < 0) begin
            return 0;
        end else if (v > top) begin
            return top;
        end
        return v;
    endfunction

    function automatic int pick_axis(input int lo, input int hi, input int top);
        int r;
        r = $urandom_range(0, 99);
        if (lo <= hi && r < 60) begin
            r = $urandom_range(0, 9);
            if (r < 2) begin
                return lo;
            end else if (r < 4) begin
                return hi;
            end
            return $urandom_range(lo, hi);
        end else if (r < 80) begin
            return $urandom_range(0, 1) ? top : 0;
        end
        return $urandom_range(0, top);
    endfunction

    function automatic int cell_addr(input int x, input int y, input int z);
        return (z * GRID_Y_DEF + y) * GRID_X_DEF + x;
    endfunction

    function automatic logic free_at(input int x, input int y, input int z);
        if (x < 0 || x > X_TOP || y < 0 || y > Y_TOP || z < 0 || z > Z_TOP) begin
            return 1'b0;
        end
        return grid_model[cell_addr(x, y, z)] == CELL_FREE;
    endfunction

    task automatic grid_predict(input t_cmd cmd, input int x, input int y, input int z,
                                input t_cell ns, output logic fr, output t_cell st);
        int   addr;
        logic in_win;
        logic z_free;
        logic xy_free;
        addr = cell_addr(x, y, z);
        fr = 1'b0;
        if (cmd == CMD_WRITE) begin
            if (ns == CELL_FREE || ns == CELL_OCCUPIED) begin
                grid_model[addr] = ns;
            end
        end else begin
            in_win = x >= win_lo_x && x <= win_hi_x && y >= win_lo_y && y <= win_hi_y &&
                     z >= win_lo_z && z <= win_hi_z;
            if (in_win && grid_model[addr] == CELL_UNKNOWN) begin
                z_free  = free_at(x, y, z - 1) || free_at(x, y, z + 1);
                xy_free = free_at(x - 1, y, z) || free_at(x + 1, y, z) ||
                          free_at(x, y - 1, z) || free_at(x, y + 1, z);
                fr = xy_free && !z_free;
            end
        end
        st = grid_model[addr];
    endtask

    task automatic send_request(input t_cmd cmd, input int x, input int y, input int z,
                                input t_cell ns, input logic typed, input logic fr_t,
                                input t_cell st_t);
        int           gap;
        logic         fr;
        t_cell        st;
        t_cell_answer ans;
        gap = pick_gap();
        repeat (gap) begin
            @(negedge i_clk);
            req_bus.valid = 1'b0;
        end
        @(negedge i_clk);
        req_bus.valid     = 1'b1;
        req_bus.cmd       = cmd;
        req_bus.cell_x    = XY_W'(x);
        req_bus.cell_y    = XY_W'(y);
        req_bus.cell_z    = Z_W'(z);
        req_bus.new_state = ns;
        do @(posedge i_clk); while (req_bus.ready !== 1'b1);
        grid_predict(cmd, x, y, z, ns, fr, st);
        if (typed) begin
            fr = fr_t;
            st = st_t;
        end
        ans.fr = fr;
        ans.st = st;
        cell_answers_due = {cell_answers_due, ans};
    endtask

    task automatic drain();
        @(negedge i_clk);
        req_bus.valid = 1'b0;
        while (cell_answers_due.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        @(negedge i_clk);
        i_cfg_we  = 1'b1;
        i_cfg_idx = idx;
        if (idx == REG_MIN_Z || idx == REG_MAX_Z) begin
            i_cfg_data = {2'($urandom_range(0, 3)), Z_W'(value)};
        end else begin
            i_cfg_data = CFG_DATA_W'(value);
        end
        case (idx)
            REG_MIN_X: win_lo_x = value;
            REG_MAX_X: win_hi_x = value;
            REG_MIN_Y: win_lo_y = value;
            REG_MAX_Y: win_hi_y = value;
            REG_MIN_Z: win_lo_z = value;
            REG_MAX_Z: win_hi_z = value;
            default: ;
        endcase
    endtask

    task automatic set_window(input int lx, input int hx, input int ly, input int hy,
                              input int lz, input int hz);
        write_reg(REG_MIN_X, lx);
        write_reg(REG_MAX_X, hx);
        write_reg(REG_MIN_Y, ly);
        write_reg(REG_MAX_Y, hy);
        write_reg(REG_MIN_Z, lz);
        write_reg(REG_MAX_Z, hz);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic random_window(input bit empty_z);
        int lx;
        int ly;
        int lz;
        lx = $urandom_range(0, X_TOP);
        ly = $urandom_range(0, Y_TOP);
        lz = $urandom_range(0, Z_TOP);
        if (empty_z) begin
            set_window(lx, $urandom_range(lx, X_TOP), ly, $urandom_range(ly, Y_TOP),
                       Z_TOP, 0);
        end else begin
            set_window(lx, $urandom_range(lx, X_TOP), ly, $urandom_range(ly, Y_TOP),
                       lz, $urandom_range(lz, Z_TOP));
        end
    endtask

    initial begin
        rsp_bus.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            stall_len = pick_gap();
            run_len   = $urandom_range(1, 8);
            repeat (stall_len) begin
                @(negedge i_clk);
                rsp_bus.ready = 1'b0;
            end
            repeat (run_len) begin
                @(negedge i_clk);
                rsp_bus.ready = 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            if (cell_answers_due.size() == 0) begin
                $display("%0t: response with no request pending: is_frontier %0d cell_state %0d",
                         $time, rsp_bus.is_frontier, rsp_bus.cell_state);
                err_count++;
            end else begin
                answer_head = cell_answers_due.pop_front();
                if (rsp_bus.is_frontier !== answer_head.fr) begin
                    $display("%0t: is_frontier expected %0d actual %0d",
                             $time, answer_head.fr, rsp_bus.is_frontier);
                    err_count++;
                end
                if (rsp_bus.cell_state !== answer_head.st) begin
                    $display("%0t: cell_state expected %0d actual %0d",
                             $time, answer_head.st, rsp_bus.cell_state);
                    err_count++;
                end
            end
        end
    end

    initial begin
        int    phase;
        int    count;
        int    cx;
        int    cy;
        int    cz;
        int    blen;
        int    r;
        t_cmd  cmd;
        t_cell ns;

        err_count   = 0;
        cycle_count = 0;
        calm        = 1'b0;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = '0;
        i_cfg_data  = '0;
        req_bus.valid     = 1'b0;
        req_bus.cmd       = CMD_WRITE;
        req_bus.cell_x    = '0;
        req_bus.cell_y    = '0;
        req_bus.cell_z    = '0;
        req_bus.new_state = CELL_UNKNOWN;
        foreach (grid_model[i]) begin
            grid_model[i] = CELL_UNKNOWN;
        end
        win_lo_x = 0;
        win_hi_x = X_TOP;
        win_lo_y = 0;
        win_hi_y = Y_TOP;
        win_lo_z = 0;
        win_hi_z = Z_TOP;

        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int i = 0; i < DIR_COUNT; i++) begin
            send_request(DIR_ROWS[i].cmd, DIR_ROWS[i].x, DIR_ROWS[i].y, DIR_ROWS[i].z,
                         DIR_ROWS[i].ns, DIR_ROWS[i].typed, DIR_ROWS[i].fr, DIR_ROWS[i].st);
        end

        for (phase = 0; phase < PHASE_COUNT; phase++) begin
            drain();
            case (phase)
                0: set_window(0, X_TOP, 0, Y_TOP, 0, Z_TOP);
                1: random_window(1'b0);
                2: set_window(33, 30, 0, Y_TOP, 0, Z_TOP);
                3: set_window(X_TOP, X_TOP, Y_TOP, Y_TOP, Z_TOP, Z_TOP);
                4: set_window(0, 0, 0, 0, 0, 0);
                5: random_window(1'b1);
                default: random_window(1'b0);
            endcase
            count = 0;
            while (count < PHASE_ITEMS) begin
                calm = ($urandom_range(0, 9) == 0);
                r = $urandom_range(0, 99);
                if (r < 80) begin
                    cx   = pick_axis(win_lo_x, win_hi_x, X_TOP);
                    cy   = pick_axis(win_lo_y, win_hi_y, Y_TOP);
                    cz   = pick_axis(win_lo_z, win_hi_z, Z_TOP);
                    blen = $urandom_range(4, 12);
                    repeat (blen) begin
                        r = $urandom_range(0, 99);
                        if (r < 52) begin
                            cmd = CMD_WRITE;
                            r = $urandom_range(0, 99);
                            if (r < 70) begin
                                ns = CELL_FREE;
                            end else if (r < 95) begin
                                ns = CELL_OCCUPIED;
                            end else begin
                                ns = t_cell'($urandom_range(0, 1) * 3);
                            end
                        end else begin
                            cmd = CMD_QUERY;
                            ns  = t_cell'($urandom_range(0, 3));
                        end
                        send_request(cmd,
                                     clamp(cx + int'($urandom_range(0, 2)) - 1, X_TOP),
                                     clamp(cy + int'($urandom_range(0, 2)) - 1, Y_TOP),
                                     clamp(cz + int'($urandom_range(0, 2)) - 1, Z_TOP),
                                     ns, 1'b0, 1'b0, CELL_UNKNOWN);
                        count++;
                    end
                end else begin
                    send_request(t_cmd'($urandom_range(0, 1)), $urandom_range(0, X_TOP),
                                 $urandom_range(0, Y_TOP), $urandom_range(0, Z_TOP),
                                 t_cell'($urandom_range(0, 3)), 1'b0, 1'b0, CELL_UNKNOWN);
                    count++;
                end
            end
        end

        calm = 1'b0;
        drain();
        repeat (40) @(posedge i_clk);
        if (err_count == 0 && cell_answers_due.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
